// ===== hw/rtl/sitl_pkg.sv =====
// Shared constants and types for the surface index table.
package sitl_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W        = 32;
  localparam int OP_W        = 3;

  localparam logic [ID_W-1:0] INVALID_ID = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 3'd0,
    OP_REGISTER  = 3'd1,
    OP_UNREG     = 3'd2,
    OP_SET_CUR   = 3'd3,
    OP_SET_RECON = 3'd4,
    OP_FIND_IDX  = 3'd5,
    OP_FIND_SURF = 3'd6,
    OP_NONE      = 3'd7
  } op_t;

  // Commands into the recency list
  typedef struct packed {
    logic             clr;
    logic             rm;
    logic             ins;
    logic [IDX_W-1:0] idx;
  } rcy_cmd_t;

  // Recency list status back to the controller
  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [IDX_W-1:0] victim;
  } rcy_stat_t;

endpackage

// ===== hw/rtl/sitl_if.sv =====
// Valid/ready channel interfaces for the surface index table.
interface sitl_in_if import sitl_pkg::*;;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [ID_W-1:0] surface_id;
  logic [3:0]      frame_index;
  modport source (output valid, operation, surface_id, frame_index, input ready);
  modport sink   (input valid, operation, surface_id, frame_index, output ready);
endinterface

interface sitl_out_if import sitl_pkg::*;;
  logic             valid;
  logic             ready;
  logic             status;
  logic             found;
  logic [3:0]       index_out;
  logic [ID_W-1:0]  surface_out;
  logic             evicted;
  logic [ID_W-1:0]  evicted_surface;
  logic [4:0]       registered_count;
  logic [ID_W-1:0]  current_target;
  logic [ID_W-1:0]  current_recon;
  modport source (output valid, status, found, index_out, surface_out, evicted,
                  evicted_surface, registered_count, current_target, current_recon,
                  input ready);
  modport sink   (input valid, status, found, index_out, surface_out, evicted,
                  evicted_surface, registered_count, current_target, current_recon,
                  output ready);
endinterface

interface sitl_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/sitl_ram.sv =====
// Generic single-port-write, registered-read RAM.
module sitl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/sitl_recency.sv =====
// Recency list: most recent at position 0, remove and insert-at-front.
module sitl_recency import sitl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  rcy_cmd_t  cmd,
  output rcy_stat_t stat
);

  logic [IDX_W-1:0] list_r [MAX_ENTRIES];
  logic [CNT_W-1:0] len_r;
  logic [CNT_W-1:0] len_nxt;
  logic [IDX_W-1:0] pos;
  logic             pos_hit;
  logic [CNT_W-1:0] ins_len;
  logic [CNT_W-1:0] len_m1;

  // First position within the list that holds the index
  always_comb begin
    pos     = '0;
    pos_hit = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!pos_hit && CNT_W'(i) < len_r && list_r[i] == cmd.idx) begin
        pos     = IDX_W'(i);
        pos_hit = 1'b1;
      end
    end
  end

  assign ins_len = (len_r >= CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES - 1) : len_r;
  assign len_m1  = len_r - CNT_W'(1);

  always_comb begin
    len_nxt = len_r;
    if (cmd.clr) begin
      len_nxt = '0;
    end else if (cmd.rm && pos_hit) begin
      len_nxt = len_r - CNT_W'(1);
    end else if (cmd.ins) begin
      len_nxt = ins_len + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  // List contents: shift left on remove, shift right on insert
  always_ff @(posedge clk) begin
    if (!cmd.clr && cmd.rm && pos_hit) begin
      for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
        if (IDX_W'(j) >= pos) begin
          list_r[j] <= list_r[j+1];
        end
      end
    end else if (!cmd.clr && cmd.ins) begin
      for (int j = 1; j < MAX_ENTRIES; j++) begin
        if (CNT_W'(j) <= ins_len) begin
          list_r[j] <= list_r[j-1];
        end
      end
      list_r[0] <= cmd.idx;
    end
  end

  assign stat.len    = len_r;
  assign stat.victim = list_r[len_m1[IDX_W-1:0]];

endmodule

// ===== hw/rtl/surface_index_table_lru.sv =====
// Surface index table top level: controller, free stack, entry memory and recency list.
//
// Maps 32-bit surface ids to frame indices with LRU eviction. One item is
// processed at a time. Surface ids live in a 16-entry RAM with registered
// read; every id lookup scans it one entry per cycle. Register, set current
// and set recon skip the scan for the invalid id and may evict an entry;
// find-surface reads the entry by index and clear runs no scan. The next
// item can be taken as soon as the result is presented, while that result
// still waits on the output.
// Capacity is written through the cfg channel and applies at the next clear;
// no clearing pass runs after reset.
module surface_index_table_lru import sitl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sitl_in_if.sink     in_ch,
  sitl_out_if.source  out_ch,
  sitl_cfg_if.sink    cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ACT, S_EVRD, S_EVUSE, S_ALLOC, S_FRM, S_FINS,
    S_SRD, S_SUSE, S_DONE
  } state_t;

  state_t           state_r;
  logic [4:0]       cap_r;
  op_t              op_r;
  logic [ID_W-1:0]  id_r;
  logic [IDX_W-1:0] fidx_r;
  logic             valid_r [MAX_ENTRIES];
  logic [IDX_W-1:0] fs_r [MAX_ENTRIES];
  logic [CNT_W-1:0] fcnt_r;
  logic [ID_W-1:0]  cur_tgt_r;
  logic [ID_W-1:0]  cur_rec_r;
  logic [IDX_W-1:0] scan_r;
  logic [IDX_W-1:0] pidx_r;
  logic             pend_r;
  logic             hit_r;
  logic [IDX_W-1:0] hidx_r;
  logic [IDX_W-1:0] vic_r;
  logic [IDX_W-1:0] idx_r;
  logic             status_r;
  logic             found_r;
  logic [ID_W-1:0]  surf_r;
  logic             ev_r;
  logic [ID_W-1:0]  evid_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ID_W-1:0]  ram_rdata;

  rcy_cmd_t         rcy_cmd;
  rcy_stat_t        rcy_stat;

  logic             in_xfer;
  logic             out_free;
  logic             scan_hit;
  logic [CNT_W-1:0] vcount;
  logic [CNT_W-1:0] fcnt_m1;
  logic [CNT_W-1:0] cap_sat;
  logic             reg_op;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign fcnt_m1  = fcnt_r - CNT_W'(1);
  assign cap_sat  = (cap_r > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : cap_r;
  assign reg_op   = (op_r == OP_REGISTER) || (op_r == OP_SET_CUR) ||
                    (op_r == OP_SET_RECON);
  assign scan_hit = pend_r && valid_r[pidx_r] && (ram_rdata == id_r);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Count of registered entries
  always_comb begin
    vcount = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      vcount = vcount + CNT_W'(valid_r[i]);
    end
  end

  // Entry memory port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = scan_r;
    ram_we    = (state_r == S_ALLOC);
    ram_waddr = fs_r[fcnt_m1[IDX_W-1:0]];
    case (state_r)
      S_SCAN:  begin ram_re = 1'b1; ram_raddr = scan_r; end
      S_EVRD:  begin ram_re = 1'b1; ram_raddr = vic_r;  end
      S_SRD:   begin ram_re = 1'b1; ram_raddr = fidx_r; end
      default: ram_re = 1'b0;
    endcase
  end

  // Recency list commands
  always_comb begin
    rcy_cmd     = '0;
    rcy_cmd.idx = idx_r;
    case (state_r)
      S_ACT: begin
        rcy_cmd.clr = (op_r == OP_CLEAR);
        rcy_cmd.rm  = (op_r == OP_UNREG) && hit_r;
        rcy_cmd.idx = hidx_r;
      end
      S_EVUSE: begin
        rcy_cmd.rm  = 1'b1;
        rcy_cmd.idx = vic_r;
      end
      S_FRM:   rcy_cmd.rm  = 1'b1;
      S_FINS:  rcy_cmd.ins = 1'b1;
      default: rcy_cmd.rm  = 1'b0;
    endcase
  end

  sitl_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_surf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (id_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sitl_recency u_recency (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (rcy_cmd),
    .stat  (rcy_stat)
  );

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 5'd16;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      cap_r <= cfg_ch.data;
    end
  end

  // Controller, table state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_ch.valid <= 1'b0;
      fcnt_r       <= CNT_W'(MAX_ENTRIES);
      cur_tgt_r    <= INVALID_ID;
      cur_rec_r    <= INVALID_ID;
      pend_r       <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        fs_r[i]    <= IDX_W'(i);
      end
    end else begin
      if (out_ch.valid && out_ch.ready && state_r != S_DONE) begin
        out_ch.valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r     <= op_t'(in_ch.operation);
            id_r     <= in_ch.surface_id;
            fidx_r   <= in_ch.frame_index;
            status_r <= 1'b1;
            found_r  <= 1'b0;
            idx_r    <= '0;
            surf_r   <= INVALID_ID;
            ev_r     <= 1'b0;
            evid_r   <= '0;
            scan_r   <= '0;
            pend_r   <= 1'b0;
            case (op_t'(in_ch.operation))
              OP_CLEAR: state_r <= S_ACT;
              OP_REGISTER, OP_SET_CUR, OP_SET_RECON:
                state_r <= (in_ch.surface_id == INVALID_ID) ? S_DONE : S_SCAN;
              OP_UNREG, OP_FIND_IDX: state_r <= S_SCAN;
              OP_FIND_SURF: state_r <= S_SRD;
              default: state_r <= S_DONE;
            endcase
          end
        end
        // One entry read per cycle, compared in the following cycle
        S_SCAN: begin
          if (scan_hit) begin
            hit_r   <= 1'b1;
            hidx_r  <= pidx_r;
            state_r <= S_ACT;
          end else if (pend_r && pidx_r == IDX_W'(MAX_ENTRIES - 1)) begin
            hit_r   <= 1'b0;
            state_r <= S_ACT;
          end else begin
            pend_r <= 1'b1;
            pidx_r <= scan_r;
            scan_r <= scan_r + IDX_W'(1);
          end
        end
        S_ACT: begin
          case (op_r)
            OP_CLEAR: begin
              status_r  <= 1'b0;
              fcnt_r    <= cap_sat;
              cur_tgt_r <= INVALID_ID;
              cur_rec_r <= INVALID_ID;
              for (int i = 0; i < MAX_ENTRIES; i++) begin
                valid_r[i] <= 1'b0;
                fs_r[i]    <= (CNT_W'(i) < cap_sat) ? IDX_W'(i) : '0;
              end
              state_r <= S_DONE;
            end
            OP_REGISTER, OP_SET_CUR, OP_SET_RECON: begin
              if (hit_r) begin
                idx_r   <= hidx_r;
                state_r <= S_FRM;
              end else if (fcnt_r != '0) begin
                state_r <= S_ALLOC;
              end else if (rcy_stat.len != '0 && valid_r[rcy_stat.victim]) begin
                vic_r   <= rcy_stat.victim;
                state_r <= S_EVRD;
              end else begin
                state_r <= S_DONE;
              end
            end
            OP_UNREG: begin
              if (hit_r) begin
                status_r        <= 1'b0;
                valid_r[hidx_r] <= 1'b0;
                if (fcnt_r < CNT_W'(MAX_ENTRIES)) begin
                  fs_r[fcnt_r[IDX_W-1:0]] <= hidx_r;
                  fcnt_r                  <= fcnt_r + CNT_W'(1);
                end
              end
              state_r <= S_DONE;
            end
            OP_FIND_IDX: begin
              if (hit_r) begin
                status_r <= 1'b0;
                found_r  <= 1'b1;
                idx_r    <= hidx_r;
              end
              state_r <= S_DONE;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_EVRD: state_r <= S_EVUSE;
        // Evict the least recent entry and return its index to the stack
        S_EVUSE: begin
          ev_r           <= 1'b1;
          evid_r         <= ram_rdata;
          valid_r[vic_r] <= 1'b0;
          if (fcnt_r < CNT_W'(MAX_ENTRIES)) begin
            fs_r[fcnt_r[IDX_W-1:0]] <= vic_r;
            fcnt_r                  <= fcnt_r + CNT_W'(1);
          end
          state_r <= S_ALLOC;
        end
        // Pop a free index; the memory write happens this cycle
        S_ALLOC: begin
          fcnt_r             <= fcnt_m1;
          idx_r              <= ram_waddr;
          valid_r[ram_waddr] <= 1'b1;
          state_r            <= S_FRM;
        end
        S_FRM: state_r <= S_FINS;
        S_FINS: begin
          status_r <= 1'b0;
          if (op_r == OP_SET_CUR) begin
            cur_tgt_r <= id_r;
          end
          if (op_r == OP_SET_RECON) begin
            cur_rec_r <= id_r;
          end
          state_r <= S_DONE;
        end
        S_SRD: state_r <= valid_r[fidx_r] ? S_SUSE : S_DONE;
        S_SUSE: begin
          status_r <= 1'b0;
          found_r  <= 1'b1;
          surf_r   <= ram_rdata;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_ch.valid            <= 1'b1;
            out_ch.status           <= status_r;
            out_ch.found            <= found_r;
            out_ch.index_out        <= idx_r;
            out_ch.surface_out      <= surf_r;
            out_ch.evicted          <= ev_r;
            out_ch.evicted_surface  <= evid_r;
            out_ch.registered_count <= vcount;
            out_ch.current_target   <= cur_tgt_r;
            out_ch.current_recon    <= cur_rec_r;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("free stack count above table size");

  a_slot_budget: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, vcount} + {1'b0, fcnt_r}) <= (CNT_W + 1)'(MAX_ENTRIES))
    else $error("registered plus free indices exceed table size");

  a_rcy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcy_stat.len <= CNT_W'(MAX_ENTRIES))
    else $error("recency list longer than table");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("second item taken while one is in flight");

  a_alloc_reg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC) |-> (reg_op && fcnt_r != '0))
    else $error("allocation without a free index");
`endif

endmodule
